// ===== sv/bdq_pkg.sv =====
package bdq_pkg;

    // Fixed field widths of the item channels
    localparam int OPCODE_W = 3;
    localparam int ITEM_W   = 16;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_TAIL = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_HEAD = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_TAIL  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_HEAD  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DELETE    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_READ      = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_REVERSE   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ITEM_W-1:0]   item_value;
        logic [POS_W-1:0]    position;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   read_value;
        logic [OCC_W-1:0]    occupancy;
        logic [OCC_W-1:0]    removed_count;
    } t_out;

    // What every cell of the chain does
    typedef enum logic [1:0] {
        C_HOLD,
        C_WRITE,
        C_SHIFT_UP,
        C_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     keep;
    } t_cell_ctl;

endpackage

// ===== sv/bdq_cell.sv =====
module bdq_cell #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16,
    parameter int IDX         = 0
) (
    input  logic                          i_clk,
    input  bdq_pkg::t_cell_ctl            i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]    i_count,
    input  logic [VALUE_WIDTH-1:0]        i_din,
    input  logic [VALUE_WIDTH-1:0]        i_head,
    input  logic [VALUE_WIDTH-1:0]        i_below,
    input  logic [VALUE_WIDTH-1:0]        i_above,
    output logic [VALUE_WIDTH-1:0]        o_value
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_IDX1 = CW'(IDX + 1);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            C_WRITE: begin
                if (i_count == MY_IDX) begin
                    n_value = i_din;
                end
            end
            C_SHIFT_UP: begin
                n_value = i_below;
            end
            C_ROT: begin
                // pull from above inside the occupied run; last slot takes the old head if it is kept
                if (MY_IDX1 < i_count) begin
                    n_value = i_above;
                end else if (MY_IDX1 == i_count && i_ctl.keep) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== sv/bdq_ctrl.sv =====
module bdq_ctrl #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bdq_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bdq_pkg::t_out                 o_out_data,
    output bdq_pkg::t_cell_ctl            o_ctl,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic [VALUE_WIDTH-1:0]        o_din,
    input  logic [VALUE_WIDTH-1:0]        i_head
);
    import bdq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } t_state;

    typedef enum logic [1:0] {
        K_DEL,
        K_READ,
        K_POP
    } t_kind;

    t_state                 r_state, n_state;
    t_kind                  r_kind, n_kind;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_rev, n_rev;
    logic [CW-1:0]          r_step, n_step;
    logic [CW-1:0]          r_last, n_last;
    logic [CW-1:0]          r_sel, n_sel;
    logic [CW-1:0]          r_n0, n_n0;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [VALUE_WIDTH-1:0] r_cap, n_cap;
    logic                   r_pend_valid, n_pend_valid;
    t_out                   r_pend, n_pend;
    logic                   r_o_valid, n_o_valid;
    t_out                   r_o, n_o;

    logic                   in_stall;
    logic                   accept;
    logic                   out_free;
    logic                   done;
    logic                   keep_now;
    logic                   cap_now;
    logic                   go_high;
    logic [CW-1:0]          pos_c;
    logic [VALUE_WIDTH-1:0] din;
    t_out                   res;
    t_cell_ctl              ctl;

    assign in_stall = (r_state != S_IDLE) || r_pend_valid;
    assign accept   = i_in_valid && !in_stall;
    assign out_free = !r_o_valid || !i_out_stall;
    assign din      = VALUE_WIDTH'(i_in_data.item_value);
    assign pos_c    = CW'(i_in_data.position);

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_count      = r_count;
        n_rev        = r_rev;
        n_step       = r_step;
        n_last       = r_last;
        n_sel        = r_sel;
        n_n0         = r_n0;
        n_val        = r_val;
        n_cap        = r_cap;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_o_valid    = r_o_valid;
        n_o          = r_o;
        ctl.op       = C_HOLD;
        ctl.keep     = 1'b0;
        done         = 1'b0;
        keep_now     = 1'b0;
        cap_now      = 1'b0;
        go_high      = 1'b0;
        res          = '0;

        // advance the pending result into the output register when it is free
        if (out_free) begin
            n_o_valid    = r_pend_valid;
            n_o          = r_pend;
            n_pend_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    done = 1'b1;
                    case (i_in_data.opcode)
                        OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                            if (r_count == CW'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                go_high = (i_in_data.opcode == OP_PUSH_TAIL) != r_rev;
                                ctl.op  = go_high ? C_WRITE : C_SHIFT_UP;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP_TAIL, OP_POP_HEAD: begin
                            if (r_count == '0) begin
                                res.status = ST_EMPTY;
                            end else if ((i_in_data.opcode == OP_POP_HEAD) != r_rev) begin
                                // low end: drop cell zero, shift the rest down
                                ctl.op         = C_ROT;
                                ctl.keep       = 1'b0;
                                res.read_value = ITEM_W'(i_head);
                                n_count        = r_count - 1'b1;
                            end else begin
                                done    = 1'b0;
                                n_state = S_SWEEP;
                                n_kind  = K_POP;
                                n_step  = '0;
                                n_last  = r_count - 1'b1;
                                n_n0    = r_count;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count != '0) begin
                                done    = 1'b0;
                                n_state = S_SWEEP;
                                n_kind  = K_DEL;
                                n_step  = '0;
                                n_last  = r_count - 1'b1;
                                n_n0    = r_count;
                                n_val   = din;
                            end
                        end
                        OP_READ: begin
                            if (CMPW'(i_in_data.position) >= CMPW'(r_count)) begin
                                res.status = ST_RANGE;
                            end else begin
                                done    = 1'b0;
                                n_state = S_SWEEP;
                                n_kind  = K_READ;
                                n_step  = '0;
                                n_last  = r_count - 1'b1;
                                n_n0    = r_count;
                                n_sel   = r_rev ? (r_count - 1'b1 - pos_c) : pos_c;
                            end
                        end
                        OP_REVERSE: begin
                            n_rev = !r_rev;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_rev   = 1'b0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // rotate the occupied run one slot per cycle, dropping entries as needed
                ctl.op = C_ROT;
                case (r_kind)
                    K_DEL:   keep_now = (i_head != r_val);
                    K_READ:  keep_now = 1'b1;
                    default: keep_now = (r_step != r_last);
                endcase
                ctl.keep = keep_now;
                if (!keep_now) begin
                    n_count = r_count - 1'b1;
                end
                cap_now = ((r_kind == K_READ) && (r_step == r_sel)) ||
                          ((r_kind == K_POP) && (r_step == r_last));
                if (cap_now) begin
                    n_cap = i_head;
                end
                if (r_step == r_last) begin
                    n_state = S_IDLE;
                    done    = 1'b1;
                    if (r_kind == K_DEL) begin
                        res.removed_count = OCC_W'(r_n0 - n_count);
                    end else begin
                        res.read_value = ITEM_W'(cap_now ? i_head : r_cap);
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            res.occupancy = OCC_W'(n_count);
            n_pend_valid  = 1'b1;
            n_pend        = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rev        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_rev        <= n_rev;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
        r_kind <= n_kind;
        r_step <= n_step;
        r_last <= n_last;
        r_sel  <= n_sel;
        r_n0   <= n_n0;
        r_val  <= n_val;
        r_cap  <= n_cap;
        r_pend <= n_pend;
        r_o    <= n_o;
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o;
    assign o_ctl       = ctl;
    assign o_count     = r_count;
    assign o_din       = din;

endmodule

// ===== sv/bounded_deque_with_delete.sv =====
// Bounded double-ended queue with delete by value.
// Input channel: i_in_valid / o_in_stall carry one opcode item (push tail, push head,
// pop tail, pop head, delete value, read position, reverse, clear). Output channel:
// o_out_valid / i_out_stall carry exactly one result item per input item: status, value
// read or popped, occupancy after the operation and count removed by a delete.
// Entries sit in a row of DEPTH cells in stored order; a flag says which end is the head.
// Push, push-front, pop at the low stored end, reverse, clear, delete on an empty queue
// and every error take one step. Delete, read and pop at the high stored end rotate the
// whole occupied run through the cells, one slot per cycle, while the input is stalled,
// before the result is formed.
// A finished result waits in a holding register while the output is stalled; an output
// register separates it from the port. A new item is accepted once the holding register
// has drained, even while the output register still waits to be taken.
// Reset (synchronous, active low) empties the queue, clears the reverse flag and drops
// any result not yet taken. Cell contents are not cleared.
module bounded_deque_with_delete #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bdq_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bdq_pkg::t_out  o_out_data
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_cell_ctl              w_ctl;
    logic [CW-1:0]          w_count;
    logic [VALUE_WIDTH-1:0] w_din;
    logic [VALUE_WIDTH-1:0] w_val [DEPTH];

    // Sequencer: decodes items, drives the cell row, holds the result registers
    bdq_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_ctl       (w_ctl),
        .o_count     (w_count),
        .o_din       (w_din),
        .i_head      (w_val[0])
    );

    // Cell row: cell zero is the low stored end; each cell sees both neighbors,
    // the new value and the current cell-zero value for rotation
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_below;
        logic [VALUE_WIDTH-1:0] w_above;

        if (gi == 0) begin : g_first
            assign w_below = w_din;
        end else begin : g_mid_lo
            assign w_below = w_val[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_above = w_val[0];
        end else begin : g_mid_hi
            assign w_above = w_val[gi+1];
        end

        bdq_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (w_count),
            .i_din   (w_din),
            .i_head  (w_val[0]),
            .i_below (w_below),
            .i_above (w_above),
            .o_value (w_val[gi])
        );
    end

`ifndef SYNTH
    // occupancy never passes the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(DEPTH))
        else $error("occupancy exceeds depth");

    // a push never lands on a full row
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == C_WRITE || w_ctl.op == C_SHIFT_UP) |-> w_count < CW'(DEPTH))
        else $error("push issued on full row");

    // rotation only over a non-empty run
    a_rot_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == C_ROT) |-> w_count != '0)
        else $error("rotation on empty row");

    // a clear empties the queue at once
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.opcode == OP_CLEAR) |=> w_count == '0)
        else $error("clear left entries behind");
`endif

endmodule
